// ----- rtl/vnf_pkg.sv -----
// Package for the value-noise fBm block: hash constants, register codes, reciprocal table.
package vnf_pkg;

  typedef logic [1:0]  cfg_idx_t;
  typedef logic [23:0] corner_t;

  localparam cfg_idx_t REG_NOISE_SEED   = 2'd0;
  localparam cfg_idx_t REG_OCTAVE_COUNT = 2'd1;

  localparam logic [31:0] HASH_KX    = 32'd374761393;
  localparam logic [31:0] HASH_KY    = 32'd668265263;
  localparam logic [31:0] HASH_KXY   = 32'd1042  + 32'd374761393 + 32'd668265263 - 32'd1042;
  localparam logic [31:0] HASH_KM    = 32'd1274126177;
  localparam logic [31:0] SEED_STEP  = 32'd31;
  localparam logic [17:0] SCALE_Q16  = 18'd133038;

  localparam int          RECIP_W     = 33;
  localparam int          RECIP_SHIFT = 40;

  // round(2^56 / ((2^k - 1) * 0xffffff)) for k = 1 .. 16
  localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
    33'd4294967552, 33'd1431655851, 33'd613566793, 33'd286331170,
    33'd138547340,  33'd68174088,   33'd33818642,  33'd16843010,
    33'd8405025,    33'd4198404,    33'd2098177,   33'd1048832,
    33'd524352,     33'd262160,     33'd131076,    33'd65537
  };

endpackage

// ----- rtl/value_noise_fbm.sv -----
// Top level of the fractal value-noise sampler: config registers, octave chain, normaliser.
//
//  channel | direction | ports                                   | moves
//  --------+-----------+-----------------------------------------+---------------------------
//  in      | sink      | in_valid/in_ready, in_x_coord,in_y_coord | one coordinate transaction
//  out     | source    | out_valid/out_ready, out_noise_value     | one sample transaction
//  cfg     | sink      | cfg_valid/cfg_ready, cfg_index, cfg_data | one register write
//
// Throughput: one coordinate per clock, sustained, when out_ready stays high.
// Depth: each octave cell is five stages deep (hash multiply, final hash multiply,
//   two blend multiplies, accumulate), then two stages of reciprocal multiply and
//   saturation.
// Reset (rst_n low, synchronous): pipeline empties, noise_seed = 7, octave_count = 3.
// Stalls: each stage holds only while it is full and the one after it is stuck, so
//   bubbles squeeze out and input is still taken while a result waits at the output.
// cfg_ready is always high; writes are expected only with the pipeline drained.
module value_noise_fbm #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_x_coord,
  input  logic signed [31:0]  in_y_coord,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_noise_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  vnf_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]         cfg_data
);
  import vnf_pkg::*;

  // coordinates grow by about one bit per octave; also wide enough for the lattice index
  localparam int CW = (32 + 2 * MAX_OCTAVES > FRAC_BITS + 32) ?
                      32 + 2 * MAX_OCTAVES : FRAC_BITS + 32;
  localparam int SW = 24 + MAX_OCTAVES;
  localparam int KW = $clog2(MAX_OCTAVES + 1);

  logic [31:0]   noise_seed_r;
  logic [3:0]    octave_count_r;
  logic [4:0]    k_clamp;
  logic [KW-1:0] k_eff;

  logic                 vld_c [MAX_OCTAVES+1];
  logic                 rdy_c [MAX_OCTAVES+1];
  logic signed [CW-1:0] x_c   [MAX_OCTAVES+1];
  logic signed [CW-1:0] y_c   [MAX_OCTAVES+1];
  logic [SW-1:0]        acc_c [MAX_OCTAVES+1];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_seed_r   <= 32'd7;
      octave_count_r <= 4'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NOISE_SEED:   noise_seed_r   <= cfg_data;
        REG_OCTAVE_COUNT: octave_count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // zero counts as one octave, anything past the chain length as the full chain
  always_comb begin
    if (octave_count_r == 4'd0) begin
      k_clamp = 5'd1;
    end else if ({1'b0, octave_count_r} > 5'(MAX_OCTAVES)) begin
      k_clamp = 5'(MAX_OCTAVES);
    end else begin
      k_clamp = {1'b0, octave_count_r};
    end
  end
  assign k_eff = KW'(k_clamp);

  // head of the chain: sign-extended coordinates, empty sum
  assign vld_c[0] = in_valid;
  assign in_ready = rdy_c[0];
  assign x_c[0]   = {{(CW-32){in_x_coord[31]}}, in_x_coord};
  assign y_c[0]   = {{(CW-32){in_y_coord[31]}}, in_y_coord};
  assign acc_c[0] = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    vnf_octave_cell #(
      .IDX (i),
      .F   (FRAC_BITS),
      .CW  (CW),
      .SW  (SW),
      .KW  (KW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .noise_seed (noise_seed_r),
      .k_eff      (k_eff),
      .up_valid   (vld_c[i]),
      .up_ready   (rdy_c[i]),
      .x_i        (x_c[i]),
      .y_i        (y_c[i]),
      .acc_i      (acc_c[i]),
      .dn_valid   (vld_c[i+1]),
      .dn_ready   (rdy_c[i+1]),
      .x_o        (x_c[i+1]),
      .y_o        (y_c[i+1]),
      .acc_o      (acc_c[i+1])
    );
  end

  // the last cell's scaled coordinates are not needed
  vnf_norm #(
    .SW (SW),
    .KW (KW)
  ) u_norm (
    .clk         (clk),
    .rst_n       (rst_n),
    .k_eff       (k_eff),
    .up_valid    (vld_c[MAX_OCTAVES]),
    .up_ready    (rdy_c[MAX_OCTAVES]),
    .sum_i       (acc_c[MAX_OCTAVES]),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .noise_value (out_noise_value)
  );

endmodule

// ----- rtl/vnf_octave_cell.sv -----
// One octave cell: hashes, smoothstep blend, Horner accumulate, coordinate scale.
module vnf_octave_cell #(
  parameter int IDX = 0,
  parameter int F   = 16,
  parameter int CW  = 48,
  parameter int SW  = 32,
  parameter int KW  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          noise_seed,
  input  logic [KW-1:0]        k_eff,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic [SW-1:0]        acc_i,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [SW-1:0]        acc_o
);
  import vnf_pkg::*;

  localparam int NS = 5;
  localparam logic signed [CW-1:0] SCALE_C = CW'(SCALE_Q16);
  localparam logic [31:0] SEED_OFS = 32'(IDX) * SEED_STEP;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  logic          active;

  // stage A
  logic [31:0]          mx_r, my_r, st_r;
  logic [2*F-1:0]       fxsq_r, fysq_r;
  logic [F-1:0]         fx_r, fy_r;
  logic signed [CW-1:0] sqx_r, sqy_r;
  logic [17:0]          srx_r, sry_r;
  logic [SW-1:0]        acc_a_r;
  // stage B
  logic [31:0]          p_r [4];
  logic [F:0]           u_r, v_b_r;
  logic signed [CW-1:0] xb_r, yb_r;
  logic [SW-1:0]        acc_b_r;
  // stage C
  corner_t              ca_r, cc_r;
  logic signed [F+26:0] e0_r, e1_r;
  logic [F:0]           v_c_r;
  logic signed [CW-1:0] xc_r, yc_r;
  logic [SW-1:0]        acc_c_r;
  // stage D
  corner_t              l0_r;
  logic signed [F+26:0] ed_r;
  logic signed [CW-1:0] xd_r, yd_r;
  logic [SW-1:0]        acc_d_r;
  // output
  logic signed [CW-1:0] xo_r, yo_r;
  logic [SW-1:0]        acc_o_r;

  // combinational
  logic [31:0]          seed_i;
  logic [33:0]          rxp, ryp;
  logic [31:0]          h [4];
  logic [31:0]          g [4];
  logic [F+1:0]         tx, ty;
  logic [2*F+1:0]       uxp, uyp;
  corner_t              cn [4];
  logic signed [24:0]   d0, d1, dd;
  logic signed [F+26:0] s0, s1, sn;
  corner_t              l1;
  logic [SW-1:0]        acc_nxt;

  assign active = k_eff > KW'(IDX);

  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // stage A: per-axis hash products, fraction squares, scale partials
  always_comb begin
    seed_i = noise_seed + SEED_OFS;
    rxp    = 34'(x_i[15:0]) * 34'(SCALE_Q16);
    ryp    = 34'(y_i[15:0]) * 34'(SCALE_Q16);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx_r    <= x_i[F+31:F] * HASH_KX;
      my_r    <= y_i[F+31:F] * HASH_KY;
      st_r    <= {seed_i[0], 31'd0} - seed_i;
      fx_r    <= x_i[F-1:0];
      fy_r    <= y_i[F-1:0];
      fxsq_r  <= (2*F)'(x_i[F-1:0]) * (2*F)'(x_i[F-1:0]);
      fysq_r  <= (2*F)'(y_i[F-1:0]) * (2*F)'(y_i[F-1:0]);
      sqx_r   <= (x_i >>> 16) * SCALE_C;
      sqy_r   <= (y_i >>> 16) * SCALE_C;
      srx_r   <= rxp[33:16];
      sry_r   <= ryp[33:16];
      acc_a_r <= acc_i;
    end
  end

  // stage B: corner hashes, smoothstep weights, scaled coordinates
  always_comb begin
    h[0] = mx_r + my_r + st_r;
    h[1] = h[0] + HASH_KX;
    h[2] = h[0] + HASH_KY;
    h[3] = h[0] + HASH_KXY;
    for (int c = 0; c < 4; c++) begin
      g[c] = h[c] ^ (h[c] >> 13);
    end
    tx  = {2'b11, {F{1'b0}}} - {1'b0, fx_r, 1'b0};
    ty  = {2'b11, {F{1'b0}}} - {1'b0, fy_r, 1'b0};
    uxp = (2*F+2)'(fxsq_r[2*F-1:F]) * (2*F+2)'(tx);
    uyp = (2*F+2)'(fysq_r[2*F-1:F]) * (2*F+2)'(ty);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < 4; c++) begin
        p_r[c] <= g[c] * HASH_KM;
      end
      u_r     <= uxp[2*F:F];
      v_b_r   <= uyp[2*F:F];
      xb_r    <= sqx_r + $signed({{(CW-18){1'b0}}, srx_r});
      yb_r    <= sqy_r + $signed({{(CW-18){1'b0}}, sry_r});
      acc_b_r <= acc_a_r;
    end
  end

  // stage C: corner values, horizontal blend products
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cn[c] = p_r[c][23:0] ^ {8'd0, p_r[c][31:16]};
    end
    d0 = $signed({1'b0, cn[1]}) - $signed({1'b0, cn[0]});
    d1 = $signed({1'b0, cn[3]}) - $signed({1'b0, cn[2]});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ca_r    <= cn[0];
      cc_r    <= cn[2];
      e0_r    <= d0 * $signed({1'b0, u_r});
      e1_r    <= d1 * $signed({1'b0, u_r});
      v_c_r   <= v_b_r;
      xc_r    <= xb_r;
      yc_r    <= yb_r;
      acc_c_r <= acc_b_r;
    end
  end

  // stage D: finish horizontal blends, vertical blend product
  always_comb begin
    s0 = $signed({{(F+3){1'b0}}, ca_r}) + (e0_r >>> F);
    s1 = $signed({{(F+3){1'b0}}, cc_r}) + (e1_r >>> F);
    l1 = s1[23:0];
    dd = $signed({1'b0, l1}) - $signed({1'b0, s0[23:0]});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      l0_r    <= s0[23:0];
      ed_r    <= dd * $signed({1'b0, v_c_r});
      xd_r    <= xc_r;
      yd_r    <= yc_r;
      acc_d_r <= acc_c_r;
    end
  end

  // stage E: octave value, Horner step (sum doubles, then adds this octave; an inactive octave passes the sum on)
  always_comb begin
    sn      = $signed({{(F+3){1'b0}}, l0_r}) + (ed_r >>> F);
    acc_nxt = active ? ({acc_d_r[SW-2:0], 1'b0} + SW'(sn[23:0])) : acc_d_r;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      xo_r    <= xd_r;
      yo_r    <= yd_r;
      acc_o_r <= acc_nxt;
    end
  end

  assign x_o   = xo_r;
  assign y_o   = yo_r;
  assign acc_o = acc_o_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !up_ready |-> (&v_r))
    else $error("cell refuses input with a free stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && !dn_ready |=> v_r[NS-1] && $stable(acc_o))
    else $error("stalled cell output lost or changed");

  a_idle_octave_pass: assert property (@(posedge clk) disable iff (!rst_n)
    en[NS-1] && v_r[NS-2] && !active |=> acc_o == $past(acc_d_r))
    else $error("inactive octave altered the sum");

endmodule

// ----- rtl/vnf_norm.sv -----
// Normaliser: sum times reciprocal of the weight total, then saturation.
module vnf_norm #(
  parameter int SW = 32,
  parameter int KW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [KW-1:0] k_eff,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [SW-1:0] sum_i,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [15:0]   noise_value
);
  import vnf_pkg::*;

  localparam int LO = SW / 2;
  localparam int HI = SW - LO;
  localparam int PW = SW + RECIP_W;

  logic [1:0]            v_r;
  logic [1:0]            en;
  logic [RECIP_W-1:0]    recip;
  logic [LO+RECIP_W-1:0] pl_r;
  logic [HI+RECIP_W-1:0] ph_r;
  logic [PW-1:0]         prod;
  logic [15:0]           res_r;
  logic [15:0]           res_nxt;

  assign en[1]    = !v_r[1] || dn_ready;
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      if (en[1]) begin
        v_r[1] <= v_r[0];
      end
    end
  end

  assign recip = RECIP_TABLE[4'(k_eff - KW'(1))];

  // split product keeps each multiplier near 32 bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r <= (LO+RECIP_W)'(sum_i[LO-1:0]) * (LO+RECIP_W)'(recip);
      ph_r <= (HI+RECIP_W)'(sum_i[SW-1:LO]) * (HI+RECIP_W)'(recip);
    end
  end

  always_comb begin
    prod = (PW'(ph_r) << LO) + PW'(pl_r);
    if (|prod[PW-1:RECIP_SHIFT+16]) begin
      res_nxt = 16'hffff;
    end else begin
      res_nxt = prod[RECIP_SHIFT+15:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res_r <= res_nxt;
    end
  end

  assign noise_value = res_r;

endmodule
